@@ hw/rtl/fen_pkg.sv @@
// ----------------------------------------------------------------------------
// fen_pkg: shared types and constants of the flood-echo node
// Request codes, register indexes, the command passed from the front end to
// the back end, and the result word.
// ----------------------------------------------------------------------------
package fen_pkg;

    // Field widths fixed by the message format.
    localparam int NODE_W = 4;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 16;
    localparam int MAP_W  = 16;

    // Sequencer index: holds node numbers up to the largest count plus two.
    localparam int IDX_W = CNT_W + 1;

    // Depth of the command queue between front and back end.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // Configuration register indexes.
    localparam logic REG_NODE_ID    = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    // Request kinds and message tags.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_MSG   = 1'b1;
    localparam logic TAG_FLOOD = 1'b0;
    localparam logic TAG_ECHO  = 1'b1;

    // Echo payloads.
    localparam logic [DATA_W-1:0] ECHO_ACK   = 16'd0;
    localparam logic [DATA_W-1:0] ECHO_CHILD = 16'd1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE
    } fen_phase_t;

    typedef enum logic [1:0] {
        BS_FIRST,
        BS_FAN,
        BS_TAIL
    } fen_bst_t;

    // One classified request: everything the back end needs to produce its
    // results without looking at the node state again.
    typedef struct packed {
        logic              fan;       // flood the data to all nodes but ex_a, ex_b
        logic [NODE_W-1:0] ex_a;
        logic [NODE_W-1:0] ex_b;
        logic [CNT_W-1:0]  cnt;       // effective node count
        logic [DATA_W-1:0] data;
        logic              ack;       // answer a late flood with an ack
        logic [NODE_W-1:0] ack_dest;
        logic              fin;       // send the closing echo to the parent
        logic [NODE_W-1:0] parent;
        logic              done;
        logic [MAP_W-1:0]  children;
    } fen_cmd_t;

    typedef struct packed {
        logic              send_valid;
        logic [NODE_W-1:0] dest;
        logic              out_tag;
        logic [DATA_W-1:0] out_value;
        logic              done_res;
        logic [MAP_W-1:0]  children;
        logic              last;
    } fen_res_t;

endpackage

@@ hw/rtl/flood_echo_node.sv @@
// ----------------------------------------------------------------------------
// flood_echo_node: one node of the flood-echo spanning-tree protocol
// Front end classifies requests and keeps the node state, a command queue
// decouples it from the back end, which sequences the outgoing results.
// ----------------------------------------------------------------------------
// A user of this block should know the following first. Requests enter through
// a queue-style port (push/full) and results leave through another (empty/pop);
// each result carries a last flag that marks the final result of its request,
// and a request that sends nothing, unless ignored, still gives one result with
// send_valid low. The front end takes one request per clock while the
// four-entry command queue has room, so received echoes and acks stream at one
// request per cycle. The back end writes one result per cycle into the output
// register while it is drained, so the result count sets the rate: a start at
// the root or the first flood at a non-root node gives one result per forwarded
// flood (node_count - 1 at the root; at a non-root node, node_count less this
// node and the parent where they lie inside the graph, so up to node_count) plus
// one for the echo to the parent when the count runs out at once. A late flood
// that brings the count of a non-root node to zero gives two results, the ack
// and the echo to the parent; every other request gives a single result. A
// request's first result passes through the command queue and the output
// register before it reaches the result port; while the back end is busy, up to
// four commands wait in the queue before full rises. Requests that the protocol
// ignores are accepted and give no result. The user must write node_id and
// node_count through the cfg port only while the node is idle; the block does
// not enforce it. node_count is used clamped to the range two to MAX_NODES, and
// never above sixteen, the most nodes that a four-bit node number can address.
// ----------------------------------------------------------------------------
module flood_echo_node
    import fen_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Configuration write port.
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [CNT_W-1:0]  cfg_data,

    // Request side.
    input  logic              push,
    output logic              full,
    input  logic              req_type,
    input  logic [NODE_W-1:0] src,
    input  logic              tag,
    input  logic [DATA_W-1:0] value,

    // Result side.
    output logic              empty,
    input  logic              pop,
    output logic              send_valid,
    output logic [NODE_W-1:0] dest,
    output logic              out_tag,
    output logic [DATA_W-1:0] out_value,
    output logic              done_res,
    output logic [MAP_W-1:0]  children,
    output logic              last
);

    logic     acc;
    logic     q_full;
    logic     cmd_push;
    fen_cmd_t cmd;
    fen_cmd_t head;
    logic     head_valid;
    logic     cmd_pop;
    logic     res_valid;
    logic     res_pop;
    fen_res_t res;

    // A request is taken whenever the command queue has a free slot; the
    // front end decides on its own whether it produces a command.
    assign full = q_full;
    assign acc  = push && !q_full;

    fen_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .acc      (acc),
        .req_type (req_type),
        .src      (src),
        .tag      (tag),
        .value    (value),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    fen_cmd_fifo u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (cmd_pop),
        .rd_data (head),
        .full    (q_full),
        .avail   (head_valid)
    );

    // The output register frees up in the same cycle it is popped, so the
    // back end can refill it back to back.
    assign res_pop = pop && res_valid;

    fen_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .cmd_pop    (cmd_pop),
        .res_pop    (res_pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign empty      = !res_valid;
    assign send_valid = res.send_valid;
    assign dest       = res.dest;
    assign out_tag    = res.out_tag;
    assign out_value  = res.out_value;
    assign done_res   = res.done_res;
    assign children   = res.children;
    assign last       = res.last;

endmodule

@@ hw/rtl/fen_front.sv @@
// ----------------------------------------------------------------------------
// fen_front: request classifier and protocol state
// Holds the configuration and the node state, updates it for each accepted
// request and issues one command for every request that yields results.
// ----------------------------------------------------------------------------
module fen_front
    import fen_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              acc,
    input  logic              req_type,
    input  logic [NODE_W-1:0] src,
    input  logic              tag,
    input  logic [DATA_W-1:0] value,
    output logic              cmd_push,
    output fen_cmd_t          cmd
);

    // Node numbers are NODE_W bits wide, so the graph never grows past the
    // nodes that such a number can address.
    localparam int N_TOP  = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int PEND_W = $clog2(2 * N_TOP - 1);

    logic [NODE_W-1:0] node_id_reg;
    logic [CNT_W-1:0]  node_count_reg;
    fen_phase_t        phase_reg, phase_next;
    logic [NODE_W-1:0] parent_reg, parent_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [MAP_W-1:0]  child_map_reg, child_map_next;

    logic [CNT_W-1:0]  n_eff;
    logic              is_root;
    logic [PEND_W-1:0] pend_full;
    logic [PEND_W-1:0] pend_fwd;
    logic [PEND_W-1:0] pend_take1;
    logic [PEND_W-1:0] pend_take2;

    assign n_eff = (node_count_reg < CNT_W'(2)) ? CNT_W'(2) :
                   (int'(node_count_reg) > N_TOP) ? CNT_W'(N_TOP) : node_count_reg;
    assign is_root    = (node_id_reg == '0);
    assign pend_full  = PEND_W'(2 * (int'(n_eff) - 1));
    assign pend_fwd   = PEND_W'(2 * int'(n_eff) - 4);
    assign pend_take1 = (pend_reg > PEND_W'(1)) ? pend_reg - PEND_W'(1) : '0;
    assign pend_take2 = (pend_reg > PEND_W'(2)) ? pend_reg - PEND_W'(2) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= '0;
            node_count_reg <= CNT_W'(2);
            phase_reg      <= PH_IDLE;
            parent_reg     <= '0;
            pend_reg       <= '0;
            child_map_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_NODE_ID:    node_id_reg    <= cfg_data[NODE_W-1:0];
                    REG_NODE_COUNT: node_count_reg <= cfg_data;
                    default:        ;
                endcase
            end
            phase_reg     <= phase_next;
            parent_reg    <= parent_next;
            pend_reg      <= pend_next;
            child_map_reg <= child_map_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        parent_next    = parent_reg;
        pend_next      = pend_reg;
        child_map_next = child_map_reg;
        cmd_push       = 1'b0;

        cmd          = '0;
        cmd.ex_a     = node_id_reg;
        cmd.ex_b     = node_id_reg;
        cmd.cnt      = n_eff;
        cmd.data     = value;
        cmd.ack_dest = src;
        cmd.parent   = parent_reg;
        cmd.children = child_map_reg;

        if (acc && phase_reg != PH_DONE)
        begin
            if (req_type == REQ_START)
            begin
                // Only an idle root starts the flood.
                if (is_root && phase_reg == PH_IDLE)
                begin
                    cmd.fan    = 1'b1;
                    cmd_push   = 1'b1;
                    pend_next  = pend_full;
                    phase_next = PH_RUN;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                // The first flood at a non-root node picks the parent.
                if (!is_root && tag == TAG_FLOOD)
                begin
                    cmd.fan     = 1'b1;
                    cmd.ex_b    = src;
                    cmd.parent  = src;
                    cmd_push    = 1'b1;
                    parent_next = src;
                    pend_next   = pend_fwd;
                    if (pend_fwd == '0)
                    begin
                        cmd.fin    = 1'b1;
                        cmd.done   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_RUN;
                    end
                end
            end
            else
            begin
                cmd_push = 1'b1;
                if (tag == TAG_ECHO)
                begin
                    if (value == ECHO_CHILD)
                    begin
                        child_map_next = child_map_reg | (MAP_W'(1) << src);
                        pend_next      = pend_take2;
                    end
                    else
                    begin
                        pend_next = pend_take1;
                    end
                end
                else
                begin
                    cmd.ack   = 1'b1;
                    pend_next = pend_take1;
                end
                cmd.children = child_map_next;
                if (pend_next == '0)
                begin
                    cmd.fin    = !is_root;
                    cmd.done   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
        end
    end

endmodule

@@ hw/rtl/fen_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// fen_cmd_fifo: command queue between front and back end
// A small first-word-fall-through queue of classified requests.
// ----------------------------------------------------------------------------
module fen_cmd_fifo
    import fen_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  fen_cmd_t wr_data,
    input  logic     rd_en,
    output fen_cmd_t rd_data,
    output logic     full,
    output logic     avail
);

    localparam int CNT_BITS = $clog2(CMDQ_DEPTH + 1);

    fen_cmd_t              mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (count_reg == CNT_BITS'(CMDQ_DEPTH));
    assign avail   = (count_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && avail;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

endmodule

@@ hw/rtl/fen_back.sv @@
// ----------------------------------------------------------------------------
// fen_back: result sequencer
// Expands each command into its results, one per cycle while the output
// register is free or popped; the consumer drains that register.
// ----------------------------------------------------------------------------
module fen_back
    import fen_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  fen_cmd_t head,
    output logic     cmd_pop,
    input  logic     res_pop,
    output logic     res_valid,
    output fen_res_t res
);

    fen_bst_t         state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg;
    fen_res_t         res_reg;
    fen_res_t         res_next;
    logic             emit;
    logic             go;
    logic [IDX_W-1:0] cnt_ext;
    logic [IDX_W-1:0] first_i;
    logic [IDX_W-1:0] first_nx;
    logic [IDX_W-1:0] fan_nx;

    // Smallest index at or above start that is neither excluded node. Two
    // exclusions can hide at most two neighbors, so three candidates suffice.
    function automatic logic [IDX_W-1:0] next_free(
        input logic [IDX_W-1:0]  start,
        input logic [NODE_W-1:0] a,
        input logic [NODE_W-1:0] b
    );
        logic [IDX_W-1:0] ea;
        logic [IDX_W-1:0] eb;
        logic [IDX_W-1:0] s1;
        logic [IDX_W-1:0] s2;
        ea = IDX_W'(a);
        eb = IDX_W'(b);
        s1 = start + IDX_W'(1);
        s2 = start + IDX_W'(2);
        if (start != ea && start != eb)
            return start;
        else if (s1 != ea && s1 != eb)
            return s1;
        else
            return s2;
    endfunction

    assign go       = head_valid && (!out_valid_reg || res_pop);
    assign cnt_ext  = IDX_W'(head.cnt);
    assign first_i  = next_free('0, head.ex_a, head.ex_b);
    assign first_nx = next_free(first_i + IDX_W'(1), head.ex_a, head.ex_b);
    assign fan_nx   = next_free(idx_reg + IDX_W'(1), head.ex_a, head.ex_b);

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_FIRST;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        cmd_pop    = 1'b0;

        res_next          = '0;
        res_next.done_res = head.done;
        res_next.children = head.children;

        case (state_reg)
            BS_FIRST:
            begin
                if (go)
                begin
                    emit = 1'b1;
                    if (head.fan && first_i < cnt_ext)
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.dest       = first_i[NODE_W-1:0];
                        res_next.out_tag    = TAG_FLOOD;
                        res_next.out_value  = head.data;
                        if (first_nx < cnt_ext)
                        begin
                            state_next = BS_FAN;
                            idx_next   = first_nx;
                        end
                        else if (head.fin)
                        begin
                            state_next = BS_TAIL;
                        end
                        else
                        begin
                            res_next.last = 1'b1;
                            cmd_pop       = 1'b1;
                        end
                    end
                    else if (head.ack)
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.dest       = head.ack_dest;
                        res_next.out_tag    = TAG_ECHO;
                        res_next.out_value  = ECHO_ACK;
                        if (head.fin)
                        begin
                            state_next = BS_TAIL;
                        end
                        else
                        begin
                            res_next.last = 1'b1;
                            cmd_pop       = 1'b1;
                        end
                    end
                    else if (head.fin)
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.dest       = head.parent;
                        res_next.out_tag    = TAG_ECHO;
                        res_next.out_value  = ECHO_CHILD;
                        res_next.last       = 1'b1;
                        cmd_pop             = 1'b1;
                    end
                    else
                    begin
                        // Nothing to send: a single empty result.
                        res_next.last = 1'b1;
                        cmd_pop       = 1'b1;
                    end
                end
            end

            BS_FAN:
            begin
                if (go)
                begin
                    emit                = 1'b1;
                    res_next.send_valid = 1'b1;
                    res_next.dest       = idx_reg[NODE_W-1:0];
                    res_next.out_tag    = TAG_FLOOD;
                    res_next.out_value  = head.data;
                    if (fan_nx < cnt_ext)
                    begin
                        idx_next = fan_nx;
                    end
                    else if (head.fin)
                    begin
                        state_next = BS_TAIL;
                    end
                    else
                    begin
                        res_next.last = 1'b1;
                        cmd_pop       = 1'b1;
                        state_next    = BS_FIRST;
                    end
                end
            end

            BS_TAIL:
            begin
                if (go)
                begin
                    emit                = 1'b1;
                    res_next.send_valid = 1'b1;
                    res_next.dest       = head.parent;
                    res_next.out_tag    = TAG_ECHO;
                    res_next.out_value  = ECHO_CHILD;
                    res_next.last       = 1'b1;
                    cmd_pop             = 1'b1;
                    state_next          = BS_FIRST;
                end
            end

            default:
            begin
                state_next = BS_FIRST;
            end
        endcase
    end

endmodule

@@ hw/rtl/flood_echo_node_checker.sv @@
// ----------------------------------------------------------------------------
// flood_echo_node_checker: port-level checks of the flood-echo node
// Watches the result port and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module flood_echo_node_checker
    import fen_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic              send_valid,
    input logic [NODE_W-1:0] dest,
    input logic              out_tag,
    input logic [DATA_W-1:0] out_value,
    input logic              done_res,
    input logic [MAP_W-1:0]  children,
    input logic              last
);

    // A waiting result stays until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before it was taken");

    // A waiting result does not change while it is not taken.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(send_valid) && $stable(dest) && $stable(out_tag)
            && $stable(out_value) && $stable(done_res) && $stable(children)
            && $stable(last))
        else $error("result changed while it was waiting");

    // A result without a message is always the only result of its request.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !send_valid |-> last)
        else $error("result without a message is not the last one");

    // A result without a message carries a cleared message body.
    a_empty_body: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !send_valid |-> dest == '0 && out_tag == 1'b0 && out_value == '0)
        else $error("result without a message carries message fields");

endmodule

bind flood_echo_node flood_echo_node_checker u_chk (.*);
